>>> sv/iqfsk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package iqfsk_pkg;

  localparam int DEF_POWER_WINDOW = 4;
  localparam int DEF_PHASE_WINDOW = 4;

  localparam int SAMPLE_W = 8;
  localparam int MAG_W    = 16;
  localparam int LOG_W    = 3;
  localparam int CROSS_W  = 17;
  localparam int THR_W    = 3;

  // largest log magnitude and largest threshold value
  localparam int LOG_MAX = 5;
  localparam int THR_MAX = 7;

  localparam logic [THR_W-1:0] THR_RESET = 3'd1;

  // squared-magnitude bounds of floor(ln|z|), ascending
  localparam int NUM_BOUNDS = 5;
  localparam logic [MAG_W-1:0] MAG_BOUND [NUM_BOUNDS] =
    '{16'd8, 16'd55, 16'd404, 16'd2981, 16'd22027};

  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  typedef struct packed {
    logic [LOG_W-1:0]          log_mag;
    logic signed [CROSS_W-1:0] xprod;
  } disc_t;

endpackage
`default_nettype wire

>>> sv/iq_fsk_demodulator.sv
`timescale 1ns / 1ps
`default_nettype none
// A sample passes the input, discriminator and window-sum registers in turn.
// Throughput: one sample per cycle while out_ready is high; the discriminator
// products and the window-sum update each take one register stage.
// Reset (rst_n low, synchronous): both windows and sums clear, previous
// sample goes to center, threshold returns to 1, pipeline empties.
module iq_fsk_demodulator import iqfsk_pkg::*; #(
  parameter int POWER_WINDOW = DEF_POWER_WINDOW,
  parameter int PHASE_WINDOW = DEF_PHASE_WINDOW
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] in_i_sample,
  input  wire logic [SAMPLE_W-1:0] in_q_sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [1:0]        out_symbol,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [THR_W-1:0]    cfg_data
);

  localparam int PWR_TW = $clog2(LOG_MAX * POWER_WINDOW + 1);
  localparam int CMP_W  = $clog2((THR_MAX + 1) * POWER_WINDOW + 1);
  localparam int PH_TW  = CROSS_W + $clog2(PHASE_WINDOW);

  logic [THR_W-1:0] thr_r;

  logic                s1_v_r, s2_v_r, s3_v_r;
  logic [SAMPLE_W-1:0] i_r, q_r, prev_i_r, prev_q_r;
  disc_t               disc, disc_r;
  logic signed [1:0]   sym_r, sym_nxt;

  logic [LOG_W-1:0]          power_line_r [POWER_WINDOW];
  logic signed [CROSS_W-1:0] phase_line_r [PHASE_WINDOW];
  logic [PWR_TW-1:0]         power_total_r, power_total_nxt;
  logic signed [PH_TW-1:0]   phase_total_r, phase_total_nxt, decision;
  logic [CMP_W-1:0]          sq_limit;

  logic s1_take, s1_move, s2_move, s2_ready, s3_ready;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // elastic pipeline control
  assign s3_ready = !s3_v_r || out_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign in_ready = !s1_v_r || s2_ready;
  assign s1_take  = in_valid && in_ready;
  assign s1_move  = s1_v_r && s2_ready;
  assign s2_move  = s2_v_r && s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        s2_v_r <= 1'b1;
      end else if (s2_move) begin
        s2_v_r <= 1'b0;
      end
      if (s2_move) begin
        s3_v_r <= 1'b1;
      end else if (out_ready) begin
        s3_v_r <= 1'b0;
      end
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (s1_take) begin
      i_r <= in_i_sample;
      q_r <= in_q_sample;
    end
  end

  iqfsk_disc u_disc (
    .cur_i  (i_r),
    .cur_q  (q_r),
    .prev_i (prev_i_r),
    .prev_q (prev_q_r),
    .res    (disc)
  );

  // stage 2: log magnitude and cross product; advance previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_i_r <= 8'd128;
      prev_q_r <= 8'd128;
    end else if (s1_move) begin
      prev_i_r <= i_r;
      prev_q_r <= q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      disc_r <= disc;
    end
  end

  // stage 3: window sums and decision
  assign power_total_nxt = power_total_r - PWR_TW'(power_line_r[POWER_WINDOW-1])
                           + PWR_TW'(disc_r.log_mag);
  assign phase_total_nxt = phase_total_r - PH_TW'(phase_line_r[PHASE_WINDOW-1])
                           + PH_TW'(disc_r.xprod);

  // floor(total / window) > threshold  <=>  total >= (threshold + 1) * window
  assign sq_limit = CMP_W'({1'b0, thr_r} + 4'd1) * CMP_W'(POWER_WINDOW);

  always_comb begin
    // on a zero sum, fall back to the sum before this update
    decision = (phase_total_nxt != '0) ? phase_total_nxt : phase_total_r;
    if (CMP_W'(power_total_nxt) >= sq_limit) begin
      sym_nxt = decision[PH_TW-1] ? SYM_NEG : SYM_POS;
    end else begin
      sym_nxt = SYM_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_total_r <= '0;
      phase_total_r <= '0;
      for (int k = 0; k < POWER_WINDOW; k++) begin
        power_line_r[k] <= '0;
      end
      for (int k = 0; k < PHASE_WINDOW; k++) begin
        phase_line_r[k] <= '0;
      end
    end else if (s2_move) begin
      power_total_r   <= power_total_nxt;
      phase_total_r   <= phase_total_nxt;
      power_line_r[0] <= disc_r.log_mag;
      phase_line_r[0] <= disc_r.xprod;
      for (int k = 1; k < POWER_WINDOW; k++) begin
        power_line_r[k] <= power_line_r[k-1];
      end
      for (int k = 1; k < PHASE_WINDOW; k++) begin
        phase_line_r[k] <= phase_line_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      sym_r <= sym_nxt;
    end
  end

  assign out_valid  = s3_v_r;
  assign out_symbol = sym_r;

endmodule
`default_nettype wire

>>> sv/iqfsk_disc.sv
`timescale 1ns / 1ps
`default_nettype none
module iqfsk_disc import iqfsk_pkg::*; (
  input  wire logic [SAMPLE_W-1:0] cur_i,
  input  wire logic [SAMPLE_W-1:0] cur_q,
  input  wire logic [SAMPLE_W-1:0] prev_i,
  input  wire logic [SAMPLE_W-1:0] prev_q,
  output disc_t                    res
);

  logic signed [SAMPLE_W-1:0] ci, cq, pi, pq;
  logic signed [MAG_W-1:0]    sq_i, sq_q, prod_a, prod_b;
  logic [MAG_W-1:0]           mag;
  logic [LOG_W-1:0]           lvl;

  // offset binary to two's complement: flip the top bit
  assign ci = {~cur_i[SAMPLE_W-1],  cur_i[SAMPLE_W-2:0]};
  assign cq = {~cur_q[SAMPLE_W-1],  cur_q[SAMPLE_W-2:0]};
  assign pi = {~prev_i[SAMPLE_W-1], prev_i[SAMPLE_W-2:0]};
  assign pq = {~prev_q[SAMPLE_W-1], prev_q[SAMPLE_W-2:0]};

  assign sq_i   = ci * ci;
  assign sq_q   = cq * cq;
  assign prod_a = pi * cq;
  assign prod_b = pq * ci;

  assign mag = $unsigned(sq_i) + $unsigned(sq_q);

  always_comb begin
    lvl = '0;
    for (int k = 0; k < NUM_BOUNDS; k++) begin
      if (mag >= MAG_BOUND[k]) begin
        lvl = lvl + LOG_W'(1);
      end
    end
  end

  assign res.log_mag = lvl;
  assign res.xprod   = CROSS_W'(prod_a) - CROSS_W'(prod_b);

endmodule
`default_nettype wire
